@@ sv/blm_pkg.sv @@
// blm_pkg: types and constants shared by the battery level monitor.
// Depends on nothing; imported by every module of the block.
package blm_pkg;

   // charge state codes (2-bit signed)
   localparam logic signed [1:0] CHARGE_ON       = 2'sb01;
   localparam logic signed [1:0] CHARGE_OFF      = 2'sb00;
   localparam logic signed [1:0] CHARGE_UNSTABLE = 2'sb11;

   // level class codes (4-bit signed)
   localparam logic signed [3:0] CLASS_UNKNOWN  = -4'sd2;
   localparam logic signed [3:0] CLASS_CRITICAL = -4'sd1;
   localparam logic signed [3:0] CLASS_0        = 4'sd0;
   localparam logic signed [3:0] CLASS_1        = 4'sd1;
   localparam logic signed [3:0] CLASS_2        = 4'sd2;
   localparam logic signed [3:0] CLASS_3        = 4'sd3;
   localparam logic signed [3:0] CLASS_4        = 4'sd4;

   // pin debounce counters
   localparam logic [5:0] SUPPLY_FULL = 6'd40;
   localparam logic [5:0] SUPPLY_STEP = 6'd4;
   localparam logic [5:0] SUPPLY_MAX  = 6'd43;
   localparam logic [4:0] CHARGE_FULL = 5'd20;

   // smoother
   localparam logic signed [11:0] CHARGE_OFFSET = 12'sd12;
   localparam logic signed [11:0] JUMP_WINDOW   = 12'sd50;
   localparam logic [6:0] HOLD_SHORT   = 7'd6;
   localparam logic [6:0] HOLD_RESTART = 7'd3;
   localparam logic [6:0] HOLD_LONG    = 7'd80;

   // hysteresis thresholds
   localparam logic signed [11:0] RISE_TO_0   = 12'sd305;
   localparam logic signed [11:0] FALL_FROM_0 = 12'sd295;
   localparam logic signed [11:0] RISE_TO_1   = 12'sd335;
   localparam logic signed [11:0] FALL_FROM_1 = 12'sd325;
   localparam logic signed [11:0] RISE_TO_2   = 12'sd365;
   localparam logic signed [11:0] FALL_FROM_2 = 12'sd355;
   localparam logic signed [11:0] RISE_TO_3   = 12'sd385;
   localparam logic signed [11:0] FALL_FROM_3 = 12'sd375;
   localparam logic signed [11:0] RISE_TO_4   = 12'sd405;
   localparam logic signed [11:0] FALL_FROM_4 = 12'sd395;

   // first classification bins
   localparam logic signed [11:0] BIN_0 = 12'sd300;
   localparam logic signed [11:0] BIN_1 = 12'sd330;
   localparam logic signed [11:0] BIN_2 = 12'sd360;
   localparam logic signed [11:0] BIN_3 = 12'sd380;
   localparam logic signed [11:0] BIN_4 = 12'sd400;

   // debounced pin status for the current word
   typedef struct packed {
      logic signed [1:0] state;
      logic              stable;
   } blm_pin_status_type;

endpackage

@@ sv/blm_debounce.sv @@
// blm_debounce: saturating counters on the supply and charge pins.
// Depends on blm_pkg.
module blm_debounce (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        started,
   input  logic                        supply_present,
   input  logic                        charge_pin,
   output blm_pkg::blm_pin_status_type pin_status
);
   import blm_pkg::*;

   logic [5:0] supply_count_ff, supply_count_in;
   logic [4:0] charge_count_ff, charge_count_in;
   logic       supply_ok, charge_ok;

   // next counter values for this word
   always_comb begin
      supply_count_in = supply_count_ff;
      charge_count_in = charge_count_ff;
      if (!started) begin
         supply_count_in = supply_present ? SUPPLY_FULL : 6'd0;
         charge_count_in = charge_pin ? 5'd0 : CHARGE_FULL;
      end else begin
         if (supply_present) begin
            if (supply_count_ff < SUPPLY_FULL) supply_count_in = supply_count_ff + SUPPLY_STEP;
         end else if (supply_count_ff != 6'd0) begin
            supply_count_in = supply_count_ff - 6'd1;
         end
         if (charge_pin) begin
            if (charge_count_ff < CHARGE_FULL) charge_count_in = charge_count_ff + 5'd1;
         end else if (charge_count_ff != 5'd0) begin
            charge_count_in = charge_count_ff - 5'd1;
         end
      end
   end

   // charge state from the updated counters
   always_comb begin
      supply_ok = (supply_count_in >= SUPPLY_FULL) || (supply_count_in == 6'd0);
      charge_ok = (charge_count_in == 5'd0) || (charge_count_in >= CHARGE_FULL);
      pin_status.stable = supply_ok && charge_ok;
      if (!(supply_ok && charge_ok))
         pin_status.state = CHARGE_UNSTABLE;
      else if ((supply_count_in >= SUPPLY_FULL) && (charge_count_in == 5'd0))
         pin_status.state = CHARGE_ON;
      else
         pin_status.state = CHARGE_OFF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         supply_count_ff <= 6'd0;
         charge_count_ff <= 5'd0;
      end else if (accept) begin
         supply_count_ff <= supply_count_in;
         charge_count_ff <= charge_count_in;
      end
   end

`ifndef SYNTHESIS
   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (supply_count_ff <= SUPPLY_MAX) && (charge_count_ff <= CHARGE_FULL))
      else $error("pin counter beyond its saturation value");
`endif

endmodule

@@ sv/blm_filter.sv @@
// blm_filter: level smoother and hysteresis classifier.
// Depends on blm_pkg; pin status comes from blm_debounce.
module blm_filter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  blm_pkg::blm_pin_status_type pin_status,
   input  logic signed [10:0]          measured_level,
   input  logic                        off_no_charge,
   output logic                        started,
   output logic signed [10:0]          level_next,
   output logic signed [3:0]           class_next
);
   import blm_pkg::*;

   logic                started_ff, started_in;
   logic                seeded_ff, seeded_in;
   logic signed [1:0]   prev_charge_ff, prev_charge_in;
   logic [6:0]          hold_count_ff, hold_count_in;
   logic [6:0]          hold_limit_ff, hold_limit_in;
   logic signed [11:0]  tracked_ff, tracked_in;
   logic signed [10:0]  level_ff, level_in;
   logic signed [3:0]   class_ff, class_in;

   logic signed [11:0]  now;
   logic signed [11:0]  sm_tracked;
   logic signed [1:0]   sm_prev;
   logic [6:0]          sm_count;
   logic [6:0]          sm_limit;
   logic                level_valid;
   logic                use_smooth;
   logic                do_classify;
   logic signed [11:0]  v;

   assign now         = {measured_level[10], measured_level};
   assign level_valid = !measured_level[10];

   // smoother step, computed for every word and committed only when used
   always_comb begin
      sm_tracked = tracked_ff;
      sm_prev    = prev_charge_ff;
      sm_count   = hold_count_ff;
      sm_limit   = hold_limit_ff;
      if (!seeded_ff) begin
         sm_tracked = (pin_status.state == CHARGE_ON) ? now - CHARGE_OFFSET : now;
         sm_prev    = pin_status.state;
      end
      // charge state flipped: short hold before tracking resumes
      if (sm_prev != pin_status.state) begin
         sm_limit = HOLD_SHORT;
         sm_count = HOLD_RESTART;
         sm_prev  = pin_status.state;
      end
      if (sm_tracked > now + CHARGE_OFFSET) sm_limit = HOLD_LONG;
      if (pin_status.state == CHARGE_UNSTABLE) begin
         sm_tracked = now;
      end else if (pin_status.state == CHARGE_ON) begin
         if (sm_count < sm_limit) begin
            sm_count   = sm_count + 7'd1;
            sm_tracked = now - CHARGE_OFFSET;
         end else if (sm_tracked < now - CHARGE_OFFSET) begin
            sm_count   = 7'd0;
            sm_tracked = sm_tracked + 12'sd1;
         end
      end else begin
         if (sm_count != 7'd0) begin
            sm_count = sm_count - 7'd1;
         end else if (sm_tracked > now) begin
            sm_tracked = sm_tracked - 12'sd1;
         end else if (sm_tracked + JUMP_WINDOW < now) begin
            sm_tracked = now;
         end
      end
   end

   // level and smoother state update
   always_comb begin
      started_in     = started_ff;
      seeded_in      = seeded_ff;
      prev_charge_in = prev_charge_ff;
      hold_count_in  = hold_count_ff;
      hold_limit_in  = hold_limit_ff;
      tracked_in     = tracked_ff;
      level_in       = level_ff;
      use_smooth     = started_ff && pin_status.stable && level_valid && !off_no_charge;
      do_classify    = started_ff ? pin_status.stable : level_valid;
      if (!started_ff) begin
         if (level_valid) begin
            started_in = 1'b1;
            level_in   = measured_level;
         end
      end else if (pin_status.stable && level_valid) begin
         level_in = off_no_charge ? measured_level : sm_tracked[10:0];
      end
      if (use_smooth) begin
         seeded_in      = 1'b1;
         prev_charge_in = sm_prev;
         hold_count_in  = sm_count;
         hold_limit_in  = sm_limit;
         tracked_in     = sm_tracked;
      end
   end

   // hysteresis classifier on the new level
   assign v = {level_in[10], level_in};

   always_comb begin
      class_in = class_ff;
      if (do_classify) begin
         case (class_ff)
            CLASS_CRITICAL: if (v > RISE_TO_0) class_in = CLASS_0;
            CLASS_0: begin
               if (v < FALL_FROM_0) class_in = CLASS_CRITICAL;
               else if (v > RISE_TO_1) class_in = CLASS_1;
            end
            CLASS_1: begin
               if (v < FALL_FROM_1) class_in = CLASS_0;
               else if (v > RISE_TO_2) class_in = CLASS_2;
            end
            CLASS_2: begin
               if (v < FALL_FROM_2) class_in = CLASS_1;
               else if (v > RISE_TO_3) class_in = CLASS_3;
            end
            CLASS_3: begin
               if (v < FALL_FROM_3) class_in = CLASS_2;
               else if (v > RISE_TO_4) class_in = CLASS_4;
            end
            CLASS_4: if (v < FALL_FROM_4) class_in = CLASS_3;
            default: begin
               if (v < BIN_0) class_in = CLASS_CRITICAL;
               else if (v < BIN_1) class_in = CLASS_0;
               else if (v < BIN_2) class_in = CLASS_1;
               else if (v < BIN_3) class_in = CLASS_2;
               else if (v < BIN_4) class_in = CLASS_3;
               else class_in = CLASS_4;
            end
         endcase
      end
   end

   assign started    = started_ff;
   assign level_next = level_in;
   assign class_next = class_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff     <= 1'b0;
         seeded_ff      <= 1'b0;
         prev_charge_ff <= CHARGE_OFF;
         hold_count_ff  <= 7'd0;
         hold_limit_ff  <= 7'd0;
         tracked_ff     <= -12'sd1;
         level_ff       <= 11'sd0;
         class_ff       <= CLASS_UNKNOWN;
      end else if (accept) begin
         started_ff     <= started_in;
         seeded_ff      <= seeded_in;
         prev_charge_ff <= prev_charge_in;
         hold_count_ff  <= hold_count_in;
         hold_limit_ff  <= hold_limit_in;
         tracked_ff     <= tracked_in;
         level_ff       <= level_in;
         class_ff       <= class_in;
      end
   end

`ifndef SYNTHESIS
   a_unstable_holds: assert property (@(posedge clock) disable iff (reset)
      accept && started_ff && !pin_status.stable |=>
         (level_ff == $past(level_ff)) && (class_ff == $past(class_ff)))
      else $error("level or class moved on an unstable word");

   a_hold_bounded: assert property (@(posedge clock) disable iff (reset)
      hold_count_ff <= HOLD_LONG)
      else $error("hold count beyond the long hold limit");

   a_class_known: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> class_ff != CLASS_UNKNOWN)
      else $error("class still unknown after the first valid level");
`endif

endmodule

@@ sv/battery_level_monitor_top.sv @@
// battery_level_monitor_top: pin debounce, level filter and result register.
// Depends on blm_pkg, blm_debounce and blm_filter.
//
//   channel | ports | payload
//   --------+-------+-----------------------------------------------------------
//   request | req_  | supply_present, charge_pin, measured_level, off_no_charge
//   result  | rsp_  | level_class, smoothed_level, charge_state
//
// One word per cycle while req_ready is high; each result is valid in the cycle
// after it is accepted; the single result register follows debounce and filter.
// Reset clears the control state; the first valid level then seeds the filter.
// A stalled result holds the request side only when the result register is full
// and not being taken in the same cycle.
module battery_level_monitor_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_supply_present,
   input  logic               req_charge_pin,
   input  logic signed [10:0] req_measured_level,
   input  logic               req_off_no_charge,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [3:0]  rsp_level_class,
   output logic signed [10:0] rsp_smoothed_level,
   output logic signed [1:0]  rsp_charge_state
);
   import blm_pkg::*;

   logic               accept;
   logic               started;
   blm_pin_status_type pin_status;
   logic signed [10:0] level_next;
   logic signed [3:0]  class_next;

   logic               rsp_valid_ff;
   logic signed [3:0]  class_ff;
   logic signed [10:0] level_ff;
   logic signed [1:0]  charge_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   blm_debounce u_debounce (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .started        (started),
      .supply_present (req_supply_present),
      .charge_pin     (req_charge_pin),
      .pin_status     (pin_status)
   );

   blm_filter u_filter (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .pin_status     (pin_status),
      .measured_level (req_measured_level),
      .off_no_charge  (req_off_no_charge),
      .started        (started),
      .level_next     (level_next),
      .class_next     (class_next)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         class_ff  <= class_next;
         level_ff  <= level_next;
         charge_ff <= pin_status.state;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_level_class    = class_ff;
   assign rsp_smoothed_level = level_ff;
   assign rsp_charge_state   = charge_ff;

`ifndef SYNTHESIS
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word produced no result");
`endif

endmodule
